// ----- sv/mmc_pkg.sv -----
//------------------------------------------------------------------------------
// mmc_pkg: shared definitions for the magnetometer min/max calibrator
// Widths, constants, command and register codes, and the structs that travel
// between the axis lanes, the merge stage and the top level.
//------------------------------------------------------------------------------
`default_nettype none

package mmc_pkg;

   // Sample and axis geometry.
   localparam int SAMPLE_BITS = 16;
   localparam int AXES        = 3;
   localparam int AXIS_BITS   = $clog2(AXES);

   // Range of two limits, its magnitude, and the centered offset.
   localparam int RANGE_BITS  = SAMPLE_BITS + 1;
   localparam int MAG_BITS    = SAMPLE_BITS;
   localparam int OFFSET_BITS = SAMPLE_BITS + 2;

   // Scale numerator and the quotient of the scale division.
   localparam int SCALE_NUM   = 10000;
   localparam int SCALE_BITS  = $clog2(SCALE_NUM + 1);
   localparam int QUOT_BITS   = SCALE_BITS + 1;
   localparam int STEP_BITS   = $clog2(SCALE_BITS);

   // Result and register widths.
   localparam int CAL_BITS     = 31;
   localparam int SPREAD_BITS  = 16;
   localparam int SPREAD_RESET = 6000;
   localparam int CMP_BITS     = ((RANGE_BITS > SPREAD_BITS) ? RANGE_BITS : SPREAD_BITS) + 1;
   localparam int CREEP_STEP   = 5;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_TDATA_BITS = ((AXES * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((AXES * CAL_BITS + 7) / 8) * 8;

   // Commands.
   localparam int CMD_BITS = 2;
   localparam logic [CMD_BITS-1:0] CMD_HOLD    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_CAPTURE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CREEP   = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPREAD_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPREAD_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPREAD_Z = 2'd2;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [RANGE_BITS-1:0]  range_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam range_type  CREEP_W    = RANGE_BITS'(CREEP_STEP);

   // Clamp an integer to the signed sample range.
   function automatic sample_type sat_sample(input int value);
      int hi;
      int lo;
      sample_type result;
      hi = (2 ** (SAMPLE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (value > hi) begin
         result = SAMPLE_MAX;
      end else if (value < lo) begin
         result = SAMPLE_MIN;
      end else begin
         result = SAMPLE_BITS'(value);
      end
      return result;
   endfunction

   // Limit values after reset, per axis.
   function automatic sample_type low_reset(input logic [AXIS_BITS-1:0] axis);
      sample_type result;
      case (axis)
         2'd0:    result = sat_sample(-2000);
         2'd1:    result = sat_sample(-2000);
         default: result = sat_sample(1000);
      endcase
      return result;
   endfunction

   function automatic sample_type high_reset(input logic [AXIS_BITS-1:0] axis);
      sample_type result;
      case (axis)
         2'd0:    result = sat_sample(-1000);
         2'd1:    result = sat_sample(-1000);
         default: result = sat_sample(4000);
      endcase
      return result;
   endfunction

   // Control from the top level and the merge stage into one lane.
   typedef struct packed {
      logic start;
      logic ack;
   } lane_ctrl_type;

   // What one lane hands to the merge stage.
   typedef struct packed {
      logic                       done;
      logic                       zero;
      logic signed [CAL_BITS-1:0] cal;
   } lane_result_type;

endpackage

`default_nettype wire

// ----- sv/mag_minmax_calibrator.sv -----
//------------------------------------------------------------------------------
// mag_minmax_calibrator: hard-iron min/max calibration of a 3-axis magnetometer
// Three axis lanes, a merge stage with the output register, and the spread
// registers.
//------------------------------------------------------------------------------
// Each transaction carries one signed sample per axis and a command. For each
// axis the sample is centered and scaled with the limits held before the
// transaction, (sample + range/2 - max) * (10000 / range), both divisions
// truncating; a zero range gives 0 and sets that axis's zero_range flag. The
// limits are then moved by the command (hold, capture extremes, creep by 5)
// and pulled in by one count at each end when wider than the spread register.
// A transaction's result is offered after the 14-step restoring divider in each
// lane, and no new transaction is accepted before it moves to the output
// register, where it waits, so a new transaction is taken while the previous
// result is still unclaimed. The user must write the spread registers through
// the csr port only while idle; the block itself does not enforce it.
//------------------------------------------------------------------------------
`default_nettype none

module mag_minmax_calibrator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request stream.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // req_tdata, from bit 0: mag_x, mag_y, mag_z.
   input  wire logic [mmc_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // req_tuser: command.
   input  wire logic [mmc_pkg::CMD_BITS-1:0]        req_tuser,
   // Response stream.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // rsp_tdata, from bit 0: cal_x, cal_y, cal_z, zero padding.
   output logic [mmc_pkg::RSP_TDATA_BITS-1:0]       rsp_tdata,
   // rsp_tuser: zero_range (x, y, z from bit 0).
   output logic [mmc_pkg::AXES-1:0]                 rsp_tuser,
   // Register write port.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mmc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [mmc_pkg::SPREAD_BITS-1:0]     csr_data
);
   import mmc_pkg::*;

   logic [SPREAD_BITS-1:0] spread_ff [AXES];
   logic [SPREAD_BITS-1:0] spread_in [AXES];
   lane_result_type        lane_res [AXES];
   lane_ctrl_type          lane_ctrl;
   logic [AXES-1:0]        lane_idle;
   logic [AXES-1:0]        done_vec;
   logic                   merge_ack;
   logic                   start;

   // Spread registers.
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         spread_in[a] = spread_ff[a];
      end
      if (csr_valid) begin
         case (csr_index)
            CSR_SPREAD_X: spread_in[0] = csr_data;
            CSR_SPREAD_Y: spread_in[1] = csr_data;
            CSR_SPREAD_Z: spread_in[2] = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            spread_ff[a] <= SPREAD_BITS'(SPREAD_RESET);
         end
      end else begin
         for (int a = 0; a < AXES; a++) begin
            spread_ff[a] <= spread_in[a];
         end
      end
   end

   assign csr_ready = 1'b1;

   // A transaction starts all lanes together once they are all free.
   assign req_tready      = &lane_idle;
   assign start           = req_tvalid && req_tready;
   assign lane_ctrl.start = start;
   assign lane_ctrl.ack   = merge_ack;

   // One lane per axis.
   for (genvar a = 0; a < AXES; a++) begin : g_lane
      mmc_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .axis    (AXIS_BITS'(a)),
         .ctrl    (lane_ctrl),
         .command (req_tuser),
         .sample  (req_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]),
         .spread  (spread_ff[a]),
         .result  (lane_res[a]),
         .idle    (lane_idle[a])
      );
      assign done_vec[a] = lane_res[a].done;
   end

   mmc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_res   (lane_res),
      .ack        (merge_ack),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Lanes leave idle right after a transaction is accepted.
   assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("lanes still idle after an accepted transaction");

   // Lanes run in lockstep and finish together.
   assert property (@(posedge clock) disable iff (reset)
      (&done_vec) || !(|done_vec))
      else $error("lanes finished out of step");

   // A zero range on x always comes with a zero x value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[CAL_BITS-1:0] == '0))
      else $error("zero range flag on x with a nonzero x value");

endmodule

`default_nettype wire

// ----- sv/mmc_lane.sv -----
//------------------------------------------------------------------------------
// mmc_lane: one axis of the calibrator
// Holds the axis limits, centers the sample, divides the scale numerator by
// the range one quotient bit per cycle, scales, and updates the limits.
//------------------------------------------------------------------------------
`default_nettype none

module mmc_lane (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [mmc_pkg::AXIS_BITS-1:0]   axis,
   input  wire mmc_pkg::lane_ctrl_type          ctrl,
   input  wire logic [mmc_pkg::CMD_BITS-1:0]    command,
   input  wire mmc_pkg::sample_type             sample,
   input  wire logic [mmc_pkg::SPREAD_BITS-1:0] spread,
   output mmc_pkg::lane_result_type             result,
   output logic                                 idle
);
   import mmc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_NARROW,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   sample_type                     low_ff, low_in;
   sample_type                     high_ff, high_in;
   sample_type                     sample_ff, sample_in;
   logic [CMD_BITS-1:0]            cmd_ff, cmd_in;
   range_type                      range_ff, range_in;
   logic signed [OFFSET_BITS-1:0]  offset_ff, offset_in;
   logic [MAG_BITS-1:0]            divisor_ff, divisor_in;
   logic [MAG_BITS-1:0]            rem_ff, rem_in;
   logic [SCALE_BITS-1:0]          quo_ff, quo_in;
   logic [STEP_BITS-1:0]           step_ff, step_in;
   logic                           neg_ff, neg_in;
   logic                           zero_ff, zero_in;
   logic signed [CAL_BITS-1:0]     cal_ff, cal_in;

   range_type                               range_now;
   range_type                               range_neg;
   range_type                               range_rnd;
   range_type                               half_w;
   range_type                               hi_sum;
   range_type                               lo_diff;
   logic signed [CMP_BITS-1:0]              range_cmp;
   logic signed [CMP_BITS-1:0]              spread_cmp;
   logic [MAG_BITS:0]                       shifted;
   logic                                    qbit;
   logic signed [QUOT_BITS-1:0]             quot_w;
   logic signed [OFFSET_BITS+QUOT_BITS-1:0] prod_w;

   // Arithmetic shared by the steps below.
   always_comb begin
      range_now  = RANGE_BITS'(high_ff) - RANGE_BITS'(low_ff);
      range_neg  = -range_ff;
      range_rnd  = range_ff + $signed({{(RANGE_BITS-1){1'b0}}, range_ff[RANGE_BITS-1]});
      half_w     = range_rnd >>> 1;
      hi_sum     = RANGE_BITS'(high_ff) + CREEP_W;
      lo_diff    = RANGE_BITS'(low_ff) - CREEP_W;
      range_cmp  = CMP_BITS'(range_now);
      spread_cmp = $signed(CMP_BITS'(spread));
      shifted    = {rem_ff, quo_ff[SCALE_BITS-1]};
      qbit       = (shifted >= {1'b0, divisor_ff});
      quot_w     = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      prod_w     = offset_ff * quot_w;
   end

   // Next-state logic of the lane sequencer.
   always_comb begin
      state_in   = state_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      sample_in  = sample_ff;
      cmd_in     = cmd_ff;
      range_in   = range_ff;
      offset_in  = offset_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      neg_in     = neg_ff;
      zero_in    = zero_ff;
      cal_in     = cal_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               sample_in = sample;
               cmd_in    = command;
               range_in  = range_now;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            // Center the sample with the old limits and set up the divider.
            offset_in  = OFFSET_BITS'(sample_ff) + OFFSET_BITS'(half_w)
                         - OFFSET_BITS'(high_ff);
            divisor_in = range_ff[RANGE_BITS-1] ? range_neg[MAG_BITS-1:0]
                                                : range_ff[MAG_BITS-1:0];
            neg_in     = range_ff[RANGE_BITS-1];
            zero_in    = (range_ff == '0);
            rem_in     = '0;
            quo_in     = SCALE_BITS'(SCALE_NUM);
            step_in    = STEP_BITS'(SCALE_BITS - 1);
            // Move the limits as the command asks.
            case (cmd_ff)
               CMD_CAPTURE: begin
                  if (high_ff < sample_ff) high_in = sample_ff;
                  if (low_ff > sample_ff)  low_in  = sample_ff;
               end
               CMD_CREEP: begin
                  if (high_ff < sample_ff) begin
                     high_in = (hi_sum > RANGE_BITS'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                                 : hi_sum[SAMPLE_BITS-1:0];
                  end
                  if (low_ff > sample_ff) begin
                     low_in = (lo_diff < RANGE_BITS'(SAMPLE_MIN)) ? SAMPLE_MIN
                                                                : lo_diff[SAMPLE_BITS-1:0];
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_NARROW;
         end
         ST_NARROW: begin
            // Pull both ends in when the range is wider than allowed.
            if (range_cmp > spread_cmp) begin
               high_in = high_ff - sample_type'(1);
               low_in  = low_ff + sample_type'(1);
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // One restoring division step per cycle.
            rem_in = qbit ? MAG_BITS'(shifted - {1'b0, divisor_ff}) : shifted[MAG_BITS-1:0];
            quo_in = {quo_ff[SCALE_BITS-2:0], qbit};
            if (step_ff == '0) begin
               state_in = ST_MUL;
            end else begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         ST_MUL: begin
            cal_in   = zero_ff ? '0 : CAL_BITS'(prod_w);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctrl.ack) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, limits and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         low_ff   <= low_reset(axis);
         high_ff  <= high_reset(axis);
      end else begin
         state_ff   <= state_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         sample_ff  <= sample_in;
         cmd_ff     <= cmd_in;
         range_ff   <= range_in;
         offset_ff  <= offset_in;
         divisor_ff <= divisor_in;
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         step_ff    <= step_in;
         neg_ff     <= neg_in;
         zero_ff    <= zero_in;
         cal_ff     <= cal_in;
      end
   end

   assign result.done = (state_ff == ST_DONE);
   assign result.zero = zero_ff;
   assign result.cal  = cal_ff;
   assign idle        = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// ----- sv/mmc_merge.sv -----
//------------------------------------------------------------------------------
// mmc_merge: combines the lane results into one output transaction
// Waits until every lane is done and the output register is free, then packs
// the calibrated values and zero-range flags and releases the lanes.
//------------------------------------------------------------------------------
`default_nettype none

module mmc_merge (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mmc_pkg::lane_result_type           lane_res [mmc_pkg::AXES],
   output logic                                    ack,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [mmc_pkg::RSP_TDATA_BITS-1:0]      rsp_tdata,
   output logic [mmc_pkg::AXES-1:0]                rsp_tuser
);
   import mmc_pkg::*;

   logic                      valid_ff, valid_in;
   logic [RSP_TDATA_BITS-1:0] tdata_ff, tdata_in;
   logic [AXES-1:0]           tuser_ff, tuser_in;
   logic [AXES-1:0]           done_vec;
   logic                      load;

   // Pack the lanes and decide when the output register takes them.
   always_comb begin
      tdata_in = '0;
      for (int a = 0; a < AXES; a++) begin
         done_vec[a]                       = lane_res[a].done;
         tdata_in[a*CAL_BITS +: CAL_BITS]  = lane_res[a].cal;
         tuser_in[a]                       = lane_res[a].zero;
      end
      load     = (&done_vec) && (!valid_ff || rsp_tready);
      valid_in = load || (valid_ff && !rsp_tready);
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            tdata_ff <= tdata_in;
            tuser_ff <= tuser_in;
         end
      end
   end

   assign ack        = load;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tuser  = tuser_ff;

endmodule

`default_nettype wire

// ----- dv/tb_mag_minmax_calibrator.sv -----
//------------------------------------------------------------------------------
// tb_mag_minmax_calibrator: self-checking bench for the min/max calibrator
// Feeds 3-axis samples with hold, capture, creep and reserved commands through
// the request stream and predicts every response from a local copy of the
// per-axis limits and spread registers. Covers zero and negative ranges, creep
// saturation, spreads of 0, 1 and 0xFFFF, and random stalls on both streams.
//------------------------------------------------------------------------------
`default_nettype none

module tb_mag_minmax_calibrator;
   timeunit 1ns;
   timeprecision 1ps;

   import mmc_pkg::*;

   // Codes the package leaves unnamed: the fourth command and the fourth index.
   localparam logic [CMD_BITS-1:0]       CMD_RESERVED = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED   = 2'd3;

   // Settle for longer than a response takes to be offered after acceptance.
   localparam int RESULT_WAIT = 24;

   typedef struct {
      logic [CMD_BITS-1:0] command;
      sample_type          mag [AXES];
   } mag_item_type;

   typedef struct {
      logic [CAL_BITS-1:0] cal [AXES];
      logic [AXES-1:0]     zero_range;
   } cal_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_TDATA_BITS-1:0]    req_tdata  = '0;
   logic [CMD_BITS-1:0]          req_tuser  = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0]    rsp_tdata;
   logic [AXES-1:0]              rsp_tuser;
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index  = '0;
   logic [SPREAD_BITS-1:0]       csr_data   = '0;

   // Local copy of the calibration state.
   longint low_lim  [AXES];
   longint high_lim [AXES];
   longint spread_reg [AXES];

   mag_item_type   pending_samples [$];
   cal_result_type expected_cals [$];
   mag_item_type   sample_on_bus;
   bit             steady = 1'b0;
   int             mismatch_count = 0;

   mag_minmax_calibrator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Each stream side takes a break with a chance of about 14 in 100 unless steady.
   function automatic bit take_break();
      return !steady && ($urandom_range(0, 99) < 14);
   endfunction

   function automatic longint clamp_sample(input longint v);
      longint result;
      result = v;
      if (v > longint'(SAMPLE_MAX)) begin
         result = longint'(SAMPLE_MAX);
      end else if (v < longint'(SAMPLE_MIN)) begin
         result = longint'(SAMPLE_MIN);
      end
      return result;
   endfunction

   // Scale each axis with the limits held so far, then move and narrow them.
   function automatic cal_result_type predict_calibration(input mag_item_type item);
      cal_result_type res;
      longint         s;
      longint         span;
      longint         cal;
      res.zero_range = '0;
      for (int a = 0; a < AXES; a++) begin
         s    = longint'(item.mag[a]);
         span = high_lim[a] - low_lim[a];
         cal  = 0;
         if (span == 0) begin
            res.zero_range[a] = 1'b1;
         end else begin
            cal = (s + (span / 2 - high_lim[a])) * (longint'(SCALE_NUM) / span);
         end
         res.cal[a] = cal[CAL_BITS-1:0];

         case (item.command)
            CMD_CAPTURE: begin
               if (high_lim[a] < s) high_lim[a] = s;
               if (low_lim[a] > s) low_lim[a] = s;
            end
            CMD_CREEP: begin
               if (high_lim[a] < s) high_lim[a] = clamp_sample(high_lim[a] + CREEP_STEP);
               if (low_lim[a] > s) low_lim[a] = clamp_sample(low_lim[a] - CREEP_STEP);
            end
            default: ;
         endcase

         if (high_lim[a] - low_lim[a] > spread_reg[a]) begin
            high_lim[a] -= 1;
            low_lim[a]  += 1;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Compare one accepted response with the oldest expectation.
   task automatic check_response();
      cal_result_type      want;
      logic [CAL_BITS-1:0] got;
      if (expected_cals.size() == 0) begin
         report_mismatch("response transaction with nothing expected");
      end else begin
         want = expected_cals.pop_front();
         for (int a = 0; a < AXES; a++) begin
            got = rsp_tdata[a*CAL_BITS +: CAL_BITS];
            if (got !== want.cal[a]) begin
               report_mismatch($sformatf("cal axis %0d got %0d want %0d",
                                         a, $signed(got), $signed(want.cal[a])));
            end
         end
         if (rsp_tuser !== want.zero_range) begin
            report_mismatch($sformatf("zero_range got %b want %b",
                                      rsp_tuser, want.zero_range));
         end
      end
   endtask

   // Request driver: predicts at acceptance, then loads the next sample.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_cals.push_back(predict_calibration(sample_on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() > 0 && !take_break()) begin
               sample_on_bus = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {sample_on_bus.mag[2], sample_on_bus.mag[1],
                              sample_on_bus.mag[0]};
               req_tuser  <= sample_on_bus.command;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random backpressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         rsp_tready <= !take_break();
      end
   end

   task automatic write_spread(input logic [CSR_INDEX_BITS-1:0] index,
                               input logic [SPREAD_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index <= CSR_SPREAD_Z) spread_reg[index] = longint'(value);
   endtask

   task automatic queue_sample(input logic [CMD_BITS-1:0] command,
                               input sample_type x, input sample_type y,
                               input sample_type z);
      mag_item_type item;
      item.command = command;
      item.mag[0]  = x;
      item.mag[1]  = y;
      item.mag[2]  = z;
      pending_samples.push_back(item);
   endtask

   // Wait until every sample is taken and every response has come back.
   task automatic drain();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_cals.size() != 0);
      repeat (RESULT_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic sample_type random_sample();
      sample_type result;
      case ($urandom_range(0, 9))
         0:       result = SAMPLE_MAX;
         1:       result = SAMPLE_MIN;
         2, 3, 4: result = SAMPLE_BITS'($urandom());
         default: result = SAMPLE_BITS'(int'($urandom_range(0, 10000)) - 5000);
      endcase
      return result;
   endfunction

   function automatic logic [CMD_BITS-1:0] random_command();
      int r;
      logic [CMD_BITS-1:0] result;
      r = $urandom_range(0, 99);
      if (r < 40) result = CMD_HOLD;
      else if (r < 65) result = CMD_CAPTURE;
      else if (r < 90) result = CMD_CREEP;
      else result = CMD_RESERVED;
      return result;
   endfunction

   task automatic queue_random(input int count);
      repeat (count) begin
         queue_sample(random_command(), random_sample(), random_sample(), random_sample());
      end
   endtask

   initial begin
      // Limits and spreads as they come out of reset.
      low_lim    = '{-2000, -2000, 1000};
      high_lim   = '{-1000, -1000, 4000};
      spread_reg = '{SPREAD_RESET, SPREAD_RESET, SPREAD_RESET};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Tight spreads on x and y pull their ranges down to zero; z stays wide.
      write_spread(CSR_SPREAD_X, 16'd0);
      write_spread(CSR_SPREAD_Y, 16'd1);
      write_spread(CSR_SPREAD_Z, 16'hFFFF);
      write_spread(CSR_UNUSED, SPREAD_BITS'($urandom()));
      @(negedge clock);

      // Field extremes and bit patterns with the limits held.
      queue_sample(CMD_HOLD, 16'sd0, 16'sd0, 16'sd0);
      queue_sample(CMD_HOLD, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      queue_sample(CMD_HOLD, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
      queue_sample(CMD_RESERVED, 16'sh5555, 16'shAAAA, 16'sh5555);
      queue_sample(CMD_HOLD, 16'shAAAA, 16'sh5555, 16'shAAAA);
      queue_sample(CMD_HOLD, -16'sd1, 16'sd1, -16'sd1);

      // Long run of held limits with random samples until x and y collapse.
      repeat (520) begin
         queue_sample(($urandom_range(0, 4) == 0) ? CMD_RESERVED : CMD_HOLD,
                      random_sample(), random_sample(), random_sample());
      end
      drain();

      // One count above a collapsed x limit turns its range negative.
      queue_sample(CMD_CAPTURE, SAMPLE_BITS'(clamp_sample(high_lim[0] + 1)),
                   SAMPLE_BITS'(clamp_sample(high_lim[1] + 1)), random_sample());
      repeat (3) queue_sample(CMD_HOLD, random_sample(), random_sample(), random_sample());

      // Capture and creep, including creep that saturates at the sample bounds.
      queue_sample(CMD_CAPTURE, 16'sd1000, -16'sd1500, 16'sd2500);
      queue_sample(CMD_CREEP, 16'sd3000, -16'sd3000, 16'sd6000);
      queue_sample(CMD_CREEP, -16'sd3000, 16'sd3000, 16'sd0);
      queue_sample(CMD_CAPTURE, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
      queue_sample(CMD_CREEP, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
      queue_sample(CMD_CAPTURE, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
      queue_sample(CMD_CREEP, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
      queue_sample(CMD_HOLD, 16'sd0, 16'sd0, 16'sd0);
      drain();

      // Widest and narrowest nonzero spreads, with no random breaks on either stream.
      write_spread(CSR_SPREAD_X, 16'hFFFF);
      write_spread(CSR_SPREAD_Y, 16'd6000);
      write_spread(CSR_SPREAD_Z, 16'd1);
      @(negedge clock);
      steady = 1'b1;
      queue_random(100);
      drain();
      steady = 1'b0;

      // Random spreads with mixed commands, paused halfway for a full drain.
      write_spread(CSR_SPREAD_X, SPREAD_BITS'($urandom_range(1, 65535)));
      write_spread(CSR_SPREAD_Y, SPREAD_BITS'($urandom_range(1, 8000)));
      write_spread(CSR_SPREAD_Z, SPREAD_BITS'($urandom_range(1, 65535)));
      @(negedge clock);
      queue_random(55);
      drain();
      queue_random(55);
      drain();

      // Anything still expected never came back.
      while (expected_cals.size() != 0) begin
         void'(expected_cals.pop_front());
         report_mismatch("expected response never arrived");
      end
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
